### sv/slfd_pkg.sv
// Shared constants, types and the graph prefix table for the line framer.
package slfd_pkg;

  localparam int LINE_BYTES = 64;
  localparam int PREFIX_LEN = 15;
  localparam int FILL_W     = $clog2(LINE_BYTES);
  localparam int PFX_W      = $clog2(PREFIX_LEN);
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);

  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_RETURN  = 8'd13;

  typedef logic [FILL_W-1:0] fill_t;

  typedef enum logic [1:0] {
    KIND_BYTE      = 2'd0,
    KIND_GRAPH_ACK = 2'd1,
    KIND_OVERFLOW  = 2'd2
  } result_kind_e;

  typedef enum logic [1:0] {
    CMD_LINE = 2'd0,
    CMD_ACK  = 2'd1,
    CMD_OVF  = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e kind;
    fill_t     len;
  } cmd_t;

  typedef struct packed {
    logic       en;
    fill_t      addr;
    logic [7:0] data;
  } mem_wr_t;

  typedef struct packed {
    result_kind_e kind;
    logic [7:0]   data;
    logic         last;
  } res_t;

  // {"type":"graph"
  function automatic logic [7:0] graph_prefix(logic [PFX_W-1:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h7B;
      4'd1:    c = 8'h22;
      4'd2:    c = 8'h74;
      4'd3:    c = 8'h79;
      4'd4:    c = 8'h70;
      4'd5:    c = 8'h65;
      4'd6:    c = 8'h22;
      4'd7:    c = 8'h3A;
      4'd8:    c = 8'h22;
      4'd9:    c = 8'h67;
      4'd10:   c = 8'h72;
      4'd11:   c = 8'h61;
      4'd12:   c = 8'h70;
      4'd13:   c = 8'h68;
      4'd14:   c = 8'h22;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

### sv/serial_line_framer_with_discard_top.sv
// Top level of the newline-delimited line framer with overflow discard.
//
// Input channel: a byte is transferred when push_i is high and full_o low.
// Result channel: the oldest result sits on result_kind_o, line_byte_o and
// last_of_run_o while empty_o is low; it is transferred when pop_i is high.
// Bytes are taken one per cycle while full_o is low. A newline that closes a
// stored line makes the front end hold full_o high until the drain engine has
// issued its last line-store read; the line store has one read port, so stored
// bytes are read one at a time. Graph-ack and overflow results pass through the
// command queue and the result queue; line bytes pass through the command queue,
// the drain state, the line-store read register and the result queue.
// A stalled receiver fills the four-entry result queue, then the two-entry
// command queue, and full_o rises; nothing is dropped.
// Reset clears line state and both queues; the line store keeps no reset and
// needs no clearing pass, since only bytes written in the current line are read.
module serial_line_framer_with_discard_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  logic [7:0] rx_byte_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       empty_o,
  output logic [1:0] result_kind_o,
  output logic [7:0] line_byte_o,
  output logic       last_of_run_o
);

  slfd_pkg::cmd_t    cmd_in, cmd_out;
  slfd_pkg::mem_wr_t mem_wr;
  logic cmd_push, cmd_full, cmd_pop, cmd_empty, drain_done;

  slfd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push_i),
    .rx_byte_i    (rx_byte_i),
    .full_o       (full_o),
    .cmdq_full_i  (cmd_full),
    .drain_done_i (drain_done),
    .cmd_push_o   (cmd_push),
    .cmd_o        (cmd_in),
    .mem_wr_o     (mem_wr)
  );

  slfd_cmdq u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_out),
    .empty_o (cmd_empty)
  );

  slfd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .mem_wr_i      (mem_wr),
    .cmd_empty_i   (cmd_empty),
    .cmd_i         (cmd_out),
    .cmd_pop_o     (cmd_pop),
    .drain_done_o  (drain_done),
    .pop_i         (pop_i),
    .empty_o       (empty_o),
    .result_kind_o (result_kind_o),
    .line_byte_o   (line_byte_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

### sv/slfd_front.sv
// Front end: accepts bytes, tracks line state, writes the line store, issues commands.
module slfd_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [7:0]       rx_byte_i,
  output logic             full_o,
  input  logic             cmdq_full_i,
  input  logic             drain_done_i,
  output logic             cmd_push_o,
  output slfd_pkg::cmd_t   cmd_o,
  output slfd_pkg::mem_wr_t mem_wr_o
);

  slfd_pkg::fill_t fill_q, fill_d;
  logic disc_q, disc_d;
  logic skip_q, skip_d;
  logic match_q, match_d;
  logic drain_pend_q, drain_pend_d;
  logic accept;
  logic in_prefix;
  logic pfx_hit;

  assign full_o    = drain_pend_q || cmdq_full_i;
  assign accept    = push_i && !full_o;
  assign in_prefix = fill_q < slfd_pkg::fill_t'(slfd_pkg::PREFIX_LEN);
  assign pfx_hit   = ((fill_q == '0) || match_q) &&
                     (rx_byte_i == slfd_pkg::graph_prefix(fill_q[slfd_pkg::PFX_W-1:0]));

  always_comb begin
    fill_d       = fill_q;
    disc_d       = disc_q;
    skip_d       = skip_q;
    match_d      = match_q;
    drain_pend_d = drain_pend_q;
    cmd_push_o   = 1'b0;
    cmd_o.kind   = slfd_pkg::CMD_LINE;
    cmd_o.len    = fill_q;
    mem_wr_o.en   = 1'b0;
    mem_wr_o.addr = fill_q;
    mem_wr_o.data = rx_byte_i;
    if (drain_done_i) begin
      drain_pend_d = 1'b0;
    end
    if (accept) begin
      if (rx_byte_i == slfd_pkg::CH_NEWLINE) begin
        fill_d = '0;
        if (skip_q) begin
          skip_d     = 1'b0;
          cmd_push_o = 1'b1;
          cmd_o.kind = slfd_pkg::CMD_ACK;
        end else if (disc_q) begin
          disc_d = 1'b0;
        end else if (fill_q != '0) begin
          cmd_push_o   = 1'b1;
          cmd_o.kind   = slfd_pkg::CMD_LINE;
          drain_pend_d = 1'b1;
        end
      end else if (rx_byte_i == slfd_pkg::CH_RETURN || skip_q || disc_q) begin
        // dropped
      end else if (fill_q >= slfd_pkg::fill_t'(slfd_pkg::LINE_BYTES - 1)) begin
        disc_d     = 1'b1;
        fill_d     = '0;
        cmd_push_o = 1'b1;
        cmd_o.kind = slfd_pkg::CMD_OVF;
      end else begin
        mem_wr_o.en = 1'b1;
        fill_d      = fill_q + 1'b1;
        if (in_prefix) begin
          match_d = pfx_hit;
          if (pfx_hit && fill_q == slfd_pkg::fill_t'(slfd_pkg::PREFIX_LEN - 1)) begin
            skip_d = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q       <= '0;
      disc_q       <= 1'b0;
      skip_q       <= 1'b0;
      match_q      <= 1'b0;
      drain_pend_q <= 1'b0;
    end else begin
      fill_q       <= fill_d;
      disc_q       <= disc_d;
      skip_q       <= skip_d;
      match_q      <= match_d;
      drain_pend_q <= drain_pend_d;
    end
  end

endmodule

### sv/slfd_cmdq.sv
// Two-entry command queue between the front end and the drain engine.
module slfd_cmdq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  slfd_pkg::cmd_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output slfd_pkg::cmd_t data_o,
  output logic           empty_o
);

  slfd_pkg::cmd_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop)  rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

### sv/slfd_back.sv
// Drain engine: line store, command execution and the result queue.
module slfd_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  slfd_pkg::mem_wr_t mem_wr_i,
  input  logic              cmd_empty_i,
  input  slfd_pkg::cmd_t    cmd_i,
  output logic              cmd_pop_o,
  output logic              drain_done_o,
  input  logic              pop_i,
  output logic              empty_o,
  output logic [1:0]        result_kind_o,
  output logic [7:0]        line_byte_o,
  output logic              last_of_run_o
);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_DRAIN = 2'b10
  } state_e;

  typedef logic [slfd_pkg::OUTQ_AW:0] ocnt_t;

  logic [7:0] line_mem [slfd_pkg::LINE_BYTES];

  state_e state_q, state_d;
  slfd_pkg::fill_t idx_q, idx_d;
  slfd_pkg::fill_t len_q, len_d;
  logic rd_vld_q, rd_last_q;
  logic [7:0] rd_data_q;
  logic issue, issue_last;

  slfd_pkg::res_t outq [slfd_pkg::OUTQ_DEPTH];
  logic [slfd_pkg::OUTQ_AW-1:0] wr_ptr_q, rd_ptr_q;
  ocnt_t out_cnt_q;
  logic out_push, out_pop;
  slfd_pkg::res_t out_res;
  slfd_pkg::res_t head;

  assign issue_last = idx_q == (len_q - 1'b1);

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    len_d        = len_q;
    issue        = 1'b0;
    cmd_pop_o    = 1'b0;
    drain_done_o = 1'b0;
    out_push     = 1'b0;
    out_res.kind = slfd_pkg::KIND_BYTE;
    out_res.data = rd_data_q;
    out_res.last = rd_last_q;
    if (rd_vld_q) begin
      out_push = 1'b1;
    end
    case (state_q)
      ST_IDLE: begin
        if (!cmd_empty_i && !rd_vld_q &&
            out_cnt_q < ocnt_t'(slfd_pkg::OUTQ_DEPTH)) begin
          cmd_pop_o = 1'b1;
          if (cmd_i.kind == slfd_pkg::CMD_LINE) begin
            state_d = ST_DRAIN;
            idx_d   = '0;
            len_d   = cmd_i.len;
          end else begin
            out_push     = 1'b1;
            out_res.data = 8'h00;
            out_res.last = 1'b1;
            out_res.kind = (cmd_i.kind == slfd_pkg::CMD_ACK) ?
                           slfd_pkg::KIND_GRAPH_ACK : slfd_pkg::KIND_OVERFLOW;
          end
        end
      end
      ST_DRAIN: begin
        if (out_cnt_q + ocnt_t'(rd_vld_q) < ocnt_t'(slfd_pkg::OUTQ_DEPTH)) begin
          issue = 1'b1;
          idx_d = idx_q + 1'b1;
          if (issue_last) begin
            state_d      = ST_IDLE;
            drain_done_o = 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_wr_i.en) begin
      line_mem[mem_wr_i.addr] <= mem_wr_i.data;
    end
    if (issue) begin
      rd_data_q <= line_mem[idx_q];
      rd_last_q <= issue_last;
    end
    if (out_push) begin
      outq[wr_ptr_q] <= out_res;
    end
  end

  assign head          = outq[rd_ptr_q];
  assign empty_o       = out_cnt_q == '0;
  assign out_pop       = pop_i && !empty_o;
  assign result_kind_o = head.kind;
  assign line_byte_o   = head.data;
  assign last_of_run_o = head.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      idx_q     <= '0;
      len_q     <= '0;
      rd_vld_q  <= 1'b0;
      wr_ptr_q  <= '0;
      rd_ptr_q  <= '0;
      out_cnt_q <= '0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      len_q    <= len_d;
      rd_vld_q <= issue;
      if (out_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (out_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      out_cnt_q <= out_cnt_q + ocnt_t'(out_push) - ocnt_t'(out_pop);
    end
  end

endmodule

### sv/slfd_checker.sv
// Port-level assertions for the line framer, bound to the top level.
module slfd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       push_i,
  input logic       full_o,
  input logic       pop_i,
  input logic       empty_o,
  input logic [1:0] result_kind_o,
  input logic [7:0] line_byte_o,
  input logic       last_of_run_o
);

  localparam logic [1:0] KindByte = 2'(slfd_pkg::KIND_BYTE);

  a_reset_empty: assert property (@(posedge clk_i) $rose(rst_ni) |-> empty_o)
    else $error("result queue not empty after reset");

  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && result_kind_o != KindByte) |-> last_of_run_o)
    else $error("ack or overflow result without last marker");

  a_single_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && result_kind_o != KindByte) |-> (line_byte_o == 8'h00))
    else $error("ack or overflow result with nonzero byte");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !pop_i) |=>
      (!empty_o && $stable(result_kind_o) && $stable(line_byte_o) &&
       $stable(last_of_run_o)))
    else $error("result changed while stalled");

endmodule

bind serial_line_framer_with_discard_top slfd_checker u_slfd_checker (.*);
